[hw/rtl/f32t_pkg.sv]
// ----------------------------------------------------------------------------
// f32t_pkg
// Shared types, constants and helper functions for the truncating
// single-precision arithmetic unit.
// ----------------------------------------------------------------------------
package f32t_pkg;

  // Word layout
  localparam int FRAC_BITS = 23;
  localparam int MAN_W     = FRAC_BITS + 1;
  localparam int EXP_W     = 8;
  localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;

  // Divider: restoring steps per pipeline stage, stage count follows
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = MAN_W / DIV_STEPS;

  // Beat latency from accept to the cycle the result is shown
  localparam int LATENCY = DIV_STAGES + 2;

  // Operation codes
  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_CMP = 3'd4
  } func_t;

  // Compare outcome codes
  localparam logic [1:0] CMP_LT = 2'b11;
  localparam logic [1:0] CMP_EQ = 2'b00;
  localparam logic [1:0] CMP_GT = 2'b01;

  // One restoring division step
  typedef struct packed {
    logic             q;
    logic [MAN_W-1:0] rem;
  } div_step_t;

  function automatic div_step_t div_step(input logic [MAN_W-1:0] rem,
                                         input logic             in_bit,
                                         input logic [MAN_W-1:0] dvs);
    logic [MAN_W:0] shifted;
    div_step_t      res;
    shifted = {rem, in_bit};
    if (shifted >= {1'b0, dvs}) begin
      res.q   = 1'b1;
      res.rem = MAN_W'(shifted - {1'b0, dvs});
    end else begin
      res.q   = 1'b0;
      res.rem = shifted[MAN_W-1:0];
    end
    return res;
  endfunction

  // Leading zero count of a significand, assumed non-zero
  function automatic logic [4:0] lzc24(input logic [MAN_W-1:0] m);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < MAN_W; i++) begin
      if (m[i]) begin
        lz = 5'(MAN_W - 1 - i);
      end
    end
    return lz;
  endfunction

endpackage

[hw/rtl/f32t_div.sv]
// ----------------------------------------------------------------------------
// f32t_div
// Pipelined restoring divider for the significand quotient
// (ma << 23) / mb, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module f32t_div (
  input  logic                       clk,
  input  logic [f32t_pkg::MAN_W-1:0] in_ma,
  input  logic [f32t_pkg::MAN_W-1:0] in_mb,
  output logic [f32t_pkg::MAN_W-1:0] out_quo
);

  localparam int MW     = f32t_pkg::MAN_W;
  localparam int Steps  = f32t_pkg::DIV_STEPS;
  localparam int Stages = f32t_pkg::DIV_STAGES;

  logic [MW-1:0] rem_r [Stages];
  logic [MW-1:0] quo_r [Stages];
  logic [MW-1:0] dvs_r [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [MW-1:0] src_rem;
    logic [MW-1:0] src_quo;
    logic [MW-1:0] src_dvs;
    logic          src_lsb;
    logic [MW-1:0] rem_nxt;
    logic [MW-1:0] quo_nxt;

    // stage source: first stage starts from the top bits of the dividend
    if (g == 0) begin : g_first
      assign src_rem = {1'b0, in_ma[MW-1:1]};
      assign src_quo = '0;
      assign src_dvs = in_mb;
      assign src_lsb = in_ma[0];
    end else begin : g_next
      assign src_rem = rem_r[g-1];
      assign src_quo = quo_r[g-1];
      assign src_dvs = dvs_r[g-1];
      assign src_lsb = 1'b0;
    end

    // a few dependent subtract steps
    always_comb begin
      f32t_pkg::div_step_t st;
      rem_nxt = src_rem;
      quo_nxt = src_quo;
      for (int j = 0; j < Steps; j++) begin
        st      = f32t_pkg::div_step(rem_nxt, (j == 0) ? src_lsb : 1'b0, src_dvs);
        rem_nxt = st.rem;
        quo_nxt = {quo_nxt[MW-2:0], st.q};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= rem_nxt;
      quo_r[g] <= quo_nxt;
      dvs_r[g] <= src_dvs;
    end
  end

  assign out_quo = quo_r[Stages-1];

endmodule

[hw/rtl/float32_truncating_arith_unit_core.sv]
// ----------------------------------------------------------------------------
// float32_truncating_arith_unit_core
// Single-precision add, subtract, multiply, divide and compare with
// truncated significands, as a fixed-latency pipeline.
// ----------------------------------------------------------------------------
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+--------------------
//  input   | in_func, in_a_word, in_b_word              | start, busy
//  result  | out_result_word, out_compare_result        | out_strobe
//
// One beat may enter every cycle; busy is never raised.
// The 8-stage divider (3 quotient bits per stage) sets the pipeline depth,
// and every operation runs through that same depth.
// Reset is synchronous and clears the valid chain only.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module float32_truncating_arith_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_func,
  input  logic [31:0]       in_a_word,
  input  logic [31:0]       in_b_word,
  output logic              out_strobe,
  output logic [31:0]       out_result_word,
  output logic signed [1:0] out_compare_result
);

  localparam int MW      = f32t_pkg::MAN_W;
  localparam int NumV    = f32t_pkg::DIV_STAGES + 1;
  localparam int TailLen = NumV - 4;

  typedef struct packed {
    f32t_pkg::func_t func;
    logic            xsgn;
    logic [7:0]      dexp;
  } tag_t;

  typedef struct packed {
    tag_t          tag;
    logic [7:0]    ae;
    logic [MW-1:0] ma;
    logic [MW-1:0] mb;
    logic          same;
    logic          as;
    logic [47:0]   prod;
    logic [7:0]    mexp;
    logic [1:0]    cmp;
  } s2_t;

  typedef struct packed {
    tag_t        tag;
    logic [MW:0] am;
    logic [7:0]  ae;
    logic        as;
    logic        azero;
    logic        same;
    logic [31:0] mword;
    logic [1:0]  cmp;
  } s3_t;

  typedef struct packed {
    tag_t        tag;
    logic [MW:0] am;
    logic [7:0]  ae;
    logic        as;
    logic        azero;
    logic        same;
    logic [4:0]  lz;
    logic [31:0] mword;
    logic [1:0]  cmp;
  } s4_t;

  typedef struct packed {
    tag_t        tag;
    logic [31:0] word;
    logic [1:0]  cmp;
  } tail_t;

  logic [NumV-1:0] vld_r, vld_nxt;
  logic            out_strobe_r;
  logic [2:0]      s1_func_r;
  logic [31:0]     s1_a_r, s1_b_r;
  s2_t             s2_r, s2_nxt;
  s3_t             s3_r, s3_nxt;
  s4_t             s4_r, s4_nxt;
  tail_t           tail_r [TailLen];
  tail_t           tail_nxt;
  logic [MW-1:0]   quo;
  logic [31:0]     out_word_r, out_word_nxt;
  logic [1:0]      out_cmp_r;

  assign busy = 1'b0;

  // valid chain
  assign vld_nxt = {vld_r[NumV-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[NumV-1];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    s1_func_r <= in_func;
    s1_a_r    <= in_a_word;
    s1_b_r    <= in_b_word;
  end

  // stage 2: unpack, align, multiply, compare
  always_comb begin
    logic          sa, sb, bs, a_lt;
    logic [7:0]    ea, eb, d;
    logic [MW-1:0] ma, mb;
    logic [1:0]    c;
    sa   = s1_a_r[31];
    sb   = s1_b_r[31];
    ea   = s1_a_r[30:23];
    eb   = s1_b_r[30:23];
    ma   = {1'b1, s1_a_r[22:0]};
    mb   = {1'b1, s1_b_r[22:0]};
    bs   = (f32t_pkg::func_t'(s1_func_r) == f32t_pkg::FN_SUB) ? ~sb : sb;
    a_lt = ea < eb;
    d    = a_lt ? 8'(eb - ea) : 8'(ea - eb);

    s2_nxt.tag.func = f32t_pkg::func_t'(s1_func_r);
    s2_nxt.tag.xsgn = sa ^ sb;
    s2_nxt.tag.dexp = 8'(f32t_pkg::EXP_BIAS + ea - eb);
    s2_nxt.ae       = a_lt ? eb : ea;
    s2_nxt.ma       = a_lt ? (ma >> d) : ma;
    s2_nxt.mb       = a_lt ? mb : (mb >> d);
    s2_nxt.same     = sa == bs;
    s2_nxt.as       = sa;
    s2_nxt.prod     = 48'(ma) * 48'(mb);
    s2_nxt.mexp     = 8'(ea + eb - f32t_pkg::EXP_BIAS);

    // sign first, then exponent, then fraction; flipped when both negative
    priority if (sa != sb) begin
      c = sa ? f32t_pkg::CMP_LT : f32t_pkg::CMP_GT;
    end else if (ea != eb) begin
      c = ((ea < eb) ^ sa) ? f32t_pkg::CMP_LT : f32t_pkg::CMP_GT;
    end else if (ma != mb) begin
      c = ((ma < mb) ^ sa) ? f32t_pkg::CMP_LT : f32t_pkg::CMP_GT;
    end else begin
      c = f32t_pkg::CMP_EQ;
    end
    s2_nxt.cmp = c;
  end

  // stage 3: magnitude add/subtract, product normalise
  always_comb begin
    logic            gt;
    logic [MW:0]     p;
    logic [MW-2:0]   mf;
    logic [7:0]      me;
    s3_nxt.tag   = s2_r.tag;
    s3_nxt.ae    = s2_r.ae;
    s3_nxt.same  = s2_r.same;
    s3_nxt.cmp   = s2_r.cmp;
    gt           = s2_r.ma > s2_r.mb;
    s3_nxt.azero = s2_r.ma == s2_r.mb;
    if (s2_r.same) begin
      s3_nxt.am = {1'b0, s2_r.ma} + {1'b0, s2_r.mb};
      s3_nxt.as = s2_r.as;
    end else begin
      s3_nxt.am = gt ? {1'b0, s2_r.ma - s2_r.mb} : {1'b0, s2_r.mb - s2_r.ma};
      s3_nxt.as = gt ? s2_r.as : ~s2_r.as;
    end
    p = s2_r.prod[47:23];
    if (p[MW]) begin
      mf = p[MW-1:1];
      me = 8'(s2_r.mexp + 8'd1);
    end else begin
      mf = p[MW-2:0];
      me = s2_r.mexp;
    end
    s3_nxt.mword = {s2_r.tag.xsgn, me, mf};
  end

  // stage 4: leading zero count for the difference
  always_comb begin
    s4_nxt.tag   = s3_r.tag;
    s4_nxt.am    = s3_r.am;
    s4_nxt.ae    = s3_r.ae;
    s4_nxt.as    = s3_r.as;
    s4_nxt.azero = s3_r.azero;
    s4_nxt.same  = s3_r.same;
    s4_nxt.lz    = f32t_pkg::lzc24(s3_r.am[MW-1:0]);
    s4_nxt.mword = s3_r.mword;
    s4_nxt.cmp   = s3_r.cmp;
  end

  // stage 5: normalise and pack, select by operation
  always_comb begin
    logic [MW-1:0] m;
    logic [7:0]    e;
    logic [31:0]   aword;
    m = '0;
    e = '0;
    if (s4_r.same) begin
      if (s4_r.am[MW]) begin
        m = s4_r.am[MW:1];
        e = 8'(s4_r.ae + 8'd1);
      end else begin
        m = s4_r.am[MW-1:0];
        e = s4_r.ae;
      end
      aword = {s4_r.as, e, m[MW-2:0]};
    end else if (s4_r.azero) begin
      aword = '0;
    end else begin
      m     = s4_r.am[MW-1:0] << s4_r.lz;
      e     = 8'(s4_r.ae - {3'b000, s4_r.lz});
      aword = {s4_r.as, e, m[MW-2:0]};
    end

    tail_nxt.tag = s4_r.tag;
    unique case (s4_r.tag.func)
      f32t_pkg::FN_ADD, f32t_pkg::FN_SUB: begin
        tail_nxt.word = aword;
        tail_nxt.cmp  = f32t_pkg::CMP_EQ;
      end
      f32t_pkg::FN_MUL: begin
        tail_nxt.word = s4_r.mword;
        tail_nxt.cmp  = f32t_pkg::CMP_EQ;
      end
      f32t_pkg::FN_CMP: begin
        tail_nxt.word = '0;
        tail_nxt.cmp  = s4_r.cmp;
      end
      default: begin
        tail_nxt.word = '0;
        tail_nxt.cmp  = f32t_pkg::CMP_EQ;
      end
    endcase
  end

  // pipeline registers (payload, no reset)
  always_ff @(posedge clk) begin
    s2_r      <= s2_nxt;
    s3_r      <= s3_nxt;
    s4_r      <= s4_nxt;
    tail_r[0] <= tail_nxt;
    for (int k = 1; k < TailLen; k++) begin
      tail_r[k] <= tail_r[k-1];
    end
  end

  // quotient runs alongside, fed from the input register
  f32t_div u_div (
    .clk     (clk),
    .in_ma   ({1'b1, s1_a_r[22:0]}),
    .in_mb   ({1'b1, s1_b_r[22:0]}),
    .out_quo (quo)
  );

  // final stage: quotient normalise and output select
  always_comb begin
    tag_t tg;
    tg = tail_r[TailLen-1].tag;
    if (tg.func == f32t_pkg::FN_DIV) begin
      if (quo[MW-1]) begin
        out_word_nxt = {tg.xsgn, tg.dexp, quo[MW-2:0]};
      end else begin
        out_word_nxt = {tg.xsgn, 8'(tg.dexp - 8'd1), quo[MW-3:0], 1'b0};
      end
    end else begin
      out_word_nxt = tail_r[TailLen-1].word;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_cmp_r  <= tail_r[TailLen-1].cmp;
  end

  assign out_strobe         = out_strobe_r;
  assign out_result_word    = out_word_r;
  assign out_compare_result = out_cmp_r;

endmodule

[hw/rtl/f32t_chk.sv]
// ----------------------------------------------------------------------------
// f32t_chk
// Port-level checks for the truncating arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module f32t_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [2:0]        in_func,
  input logic              out_strobe,
  input logic [31:0]       out_result_word,
  input logic signed [1:0] out_compare_result
);

  localparam int Lat = f32t_pkg::LATENCY;

  // every result beat comes from an accepted beat a fixed time earlier
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, Lat))
    else $error("result beat without matching accept");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_strobe)
    else $error("result beat straight after reset");

  // compare outcome only for compare beats
  a_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ($past(in_func, Lat) != f32t_pkg::FN_CMP) |-> out_compare_result == 2'sd0)
    else $error("compare outcome on arithmetic beat");

  // compare beats carry a zero word and a valid outcome code
  a_cmp_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ($past(in_func, Lat) == f32t_pkg::FN_CMP)
      |-> out_result_word == 32'd0 && out_compare_result != 2'b10)
    else $error("bad compare beat");

endmodule

bind float32_truncating_arith_unit_core f32t_chk u_f32t_chk (.*);

[dv/float32_truncating_arith_unit_checker.sv]
// ----------------------------------------------------------------------------
// float32_truncating_arith_unit_checker
// Watches the operand and result channels of the truncating single-precision
// unit, works out the expected word and compare outcome of each accepted
// beat and checks every result beat against the oldest one waiting.
// ----------------------------------------------------------------------------
module float32_truncating_arith_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        in_func,
  input  logic [31:0]       in_a_word,
  input  logic [31:0]       in_b_word,
  input  logic              out_strobe,
  input  logic [31:0]       out_result_word,
  input  logic signed [1:0] out_compare_result,
  output int                err_count,
  output int                pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  cmp;
  } fp_outcome_t;

  localparam logic [31:0] HIDDEN_BIT = 32'h0080_0000;
  localparam logic [31:0] CARRY_BIT  = 32'h0100_0000;

  fp_outcome_t outcome_q[$];

  function automatic logic [31:0] pack_word(logic s, logic [7:0] e, logic [31:0] m);
    return {s, e, m[f32t_pkg::FRAC_BITS-1:0]};
  endfunction

  function automatic logic [31:0] signif(logic [31:0] w);
    return {8'd0, 1'b1, w[f32t_pkg::FRAC_BITS-1:0]};
  endfunction

  // Add magnitudes with b carrying sign bs; unlike signs subtract
  function automatic logic [31:0] add_words(logic [31:0] a, logic [31:0] b, logic bs);
    logic [7:0]  ea, eb, e;
    logic [31:0] ma, mb, m;
    logic [8:0]  d;
    logic        s;
    ea = a[30:23];
    eb = b[30:23];
    ma = signif(a);
    mb = signif(b);
    if (ea < eb) begin
      e  = eb;
      d  = {1'b0, 8'(eb - ea)};
      ma = (d >= 32) ? 32'd0 : ma >> d;
    end else begin
      e  = ea;
      d  = {1'b0, 8'(ea - eb)};
      mb = (d >= 32) ? 32'd0 : mb >> d;
    end
    if (a[31] == bs) begin
      m = ma + mb;
      while (m >= CARRY_BIT) begin
        e++;
        m = m >> 1;
      end
      return pack_word(a[31], e, m);
    end
    if (ma > mb) begin
      s = a[31];
      m = ma - mb;
    end else if (ma < mb) begin
      s = ~a[31];
      m = mb - ma;
    end else begin
      return 32'd0;
    end
    while (m < HIDDEN_BIT) begin
      e--;
      m = m << 1;
    end
    return pack_word(s, e, m);
  endfunction

  function automatic logic [31:0] renorm(logic s, logic [7:0] e, logic [63:0] m);
    while (m >= 64'(CARRY_BIT)) begin
      e++;
      m = m >> 1;
    end
    while (m != 0 && m < 64'(HIDDEN_BIT)) begin
      e--;
      m = m << 1;
    end
    return pack_word(s, e, m[31:0]);
  endfunction

  // Sign first, then exponent, then fraction; reversed when both negative
  function automatic logic [1:0] order_words(logic [31:0] a, logic [31:0] b);
    logic gt;
    if (a[31] != b[31]) return a[31] ? f32t_pkg::CMP_LT : f32t_pkg::CMP_GT;
    if (a[30:0] == b[30:0]) return f32t_pkg::CMP_EQ;
    gt = a[30:0] > b[30:0];
    if (a[31]) gt = ~gt;
    return gt ? f32t_pkg::CMP_GT : f32t_pkg::CMP_LT;
  endfunction

  function automatic fp_outcome_t predict_outcome(logic [2:0] fn, logic [31:0] a,
                                                  logic [31:0] b);
    fp_outcome_t r;
    logic [63:0] p;
    r = '0;
    case (fn)
      f32t_pkg::FN_ADD: r.word = add_words(a, b, b[31]);
      f32t_pkg::FN_SUB: r.word = add_words(a, b, ~b[31]);
      f32t_pkg::FN_MUL: begin
        p      = (64'(signif(a)) * 64'(signif(b))) >> f32t_pkg::FRAC_BITS;
        r.word = renorm(a[31] ^ b[31],
                        8'(a[30:23] + b[30:23] - f32t_pkg::EXP_BIAS), p);
      end
      f32t_pkg::FN_DIV: begin
        p      = (64'(signif(a)) << f32t_pkg::FRAC_BITS) / 64'(signif(b));
        r.word = renorm(a[31] ^ b[31],
                        8'(f32t_pkg::EXP_BIAS + a[30:23] - b[30:23]), p);
      end
      f32t_pkg::FN_CMP: r.cmp = order_words(a, b);
      default: ;
    endcase
    return r;
  endfunction

  // Predict on operand beats, compare on result beats
  always @(posedge clk) begin
    fp_outcome_t exp_r;
    if (rst_n) begin
      if (start && !busy) outcome_q.push_back(predict_outcome(in_func, in_a_word, in_b_word));
      if (out_strobe) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected: word %h cmp %0d",
                 out_result_word, out_compare_result);
          err_count++;
        end else begin
          exp_r = outcome_q.pop_front();
          if (out_result_word !== exp_r.word) begin
            $error("result_word: expected %h, got %h", exp_r.word, out_result_word);
            err_count++;
          end
          if (out_compare_result !== exp_r.cmp) begin
            $error("compare_result: expected %0d, got %0d",
                   $signed(exp_r.cmp), out_compare_result);
            err_count++;
          end
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

[dv/float32_truncating_arith_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// float32_truncating_arith_unit_core_tb
// Drives directed corner operands and then about a thousand random beats,
// many shaped for cancellation and near/far alignment, with random gaps and
// back-to-back stretches; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module float32_truncating_arith_unit_core_tb;

  localparam int          N_RANDOM  = 1100;
  localparam int          IDLE_LIMIT = 2000;
  localparam logic [2:0]  FN_UNUSED = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_func = '0;
  logic [31:0]       in_a_word = '0;
  logic [31:0]       in_b_word = '0;
  logic              out_strobe;
  logic [31:0]       out_result_word;
  logic signed [1:0] out_compare_result;
  int                err_count, pending;
  int                beats_sent = 0;
  int                idle_cycles = 0;
  bit                no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  float32_truncating_arith_unit_core dut (.*);

  float32_truncating_arith_unit_checker chk (.*);

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one beat, wait for accept, then an optional gap
  task automatic send_op(logic [2:0] fn, logic [31:0] a, logic [31:0] b);
    int gap;
    start     <= 1'b1;
    in_func   <= fn;
    in_a_word <= a;
    in_b_word <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Operand pair shaped for the interesting add/sub and compare regions
  task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
    a = $urandom();
    b = $urandom();
    case ($urandom_range(0, 5))
      0: b = a ^ 32'h8000_0000;                           // equal magnitudes
      1: b = {1'($urandom_range(0, 1)), a[30:0] ^ (31'h1 << $urandom_range(0, 22))};
      2: b[30:23] = a[30:23] + 8'($urandom_range(0, 3)); // close exponents
      3: b[30:23] = a[30:23] + 8'($urandom_range(24, 40)); // far alignment
      4: b = a;
      default: ;
    endcase
  endtask

  initial begin
    logic [31:0] a, b;
    f32t_pkg::func_t fl[5];
    fl = '{f32t_pkg::FN_ADD, f32t_pkg::FN_SUB, f32t_pkg::FN_MUL, f32t_pkg::FN_DIV,
           f32t_pkg::FN_CMP};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every operation, sign and cancellation cases
    foreach (fl[i]) begin
      send_op(fl[i], 32'h3F80_0000, 32'h4000_0000);
      send_op(fl[i], 32'hFFFF_FFFF, 32'h0000_0000);
      send_op(fl[i], 32'h8000_0000, 32'h0000_0000);
      send_op(fl[i], 32'h4040_0000, 32'hC040_0000);
    end
    send_op(f32t_pkg::FN_ADD, 32'h3F80_0000, 32'hBF80_0000);   // exact cancellation
    send_op(f32t_pkg::FN_SUB, 32'h4000_0000, 32'h4000_0000);
    send_op(f32t_pkg::FN_ADD, 32'h7F00_0000, 32'h0080_0000);   // far alignment
    send_op(f32t_pkg::FN_MUL, 32'h7F7F_FFFF, 32'h7F7F_FFFF);   // exponent wrap
    send_op(FN_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0);

    // Random: mostly shaped pairs, alternating gap and back-to-back stretches
    for (int n = 0; n < N_RANDOM; n++) begin
      no_gaps = ((n / 100) % 3) == 2;
      random_pair(a, b);
      send_op($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                         : 3'(fl[$urandom_range(0, 4)]), a, b);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (f32t_pkg::LATENCY + 5) @(posedge clk);
    $display("covered %0d beats: all operations, unused codes, cancellation,", beats_sent);
    $display("near and far alignment, exponent wrap and signed compares");
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
